// ----- hdl/pcr_pkg.sv -----
// shared types and constants for the particle collision response block
package pcr_pkg;

	// packed register layout: three signed slices, x lowest
	localparam int SLICE_W = 16;
	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int AXES = 3;

	// plane normal reset value: +y in Q2.14
	localparam logic [CFG_W-1:0] PLANE_NORMAL_RESET = 48'h0000_4000_0000;

	// plane dot product rescale, Q8.8 * Q2.14 down to Q8.14
	localparam int DOT_SHIFT = 8;
	localparam int DOT_ROUND = 128;

	// plane correction rescale, 2 * Q8.14 * Q2.14 down to Q8.8
	localparam int CORR_SHIFT = 19;
	localparam int CORR_ROUND = 262144;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPHERE_CENTER = 2'd0,
		CFG_BOX_MIN       = 2'd1,
		CFG_BOX_MAX       = 2'd2,
		CFG_PLANE_NORMAL  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_SPHERE = 2'd0,
		KIND_BOX    = 2'd1,
		KIND_PLANE  = 2'd2
	} kind_t;

	// one signed slice of a packed register
	function automatic logic signed [SLICE_W-1:0] cfg_slice(input logic [CFG_W-1:0] r,
			input logic [1:0] k);
		cfg_slice = r[k*SLICE_W +: SLICE_W];
	endfunction

endpackage

// ----- hdl/pcr_if.sv -----
// valid/ready channels for particle items and response items
interface pcr_in_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] vel_x;
	logic signed [COORD_WIDTH-1:0] vel_y;
	logic signed [COORD_WIDTH-1:0] vel_z;

	modport source(output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface pcr_out_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_vel_x;
	logic signed [COORD_WIDTH-1:0] out_vel_y;
	logic signed [COORD_WIDTH-1:0] out_vel_z;
	logic                          passed_through;
	logic                          saturated;

	modport source(output valid, out_vel_x, out_vel_y, out_vel_z, passed_through, saturated,
		input ready);
	modport sink(input valid, out_vel_x, out_vel_y, out_vel_z, passed_through, saturated,
		output ready);
endinterface

// ----- hdl/pcr_div.sv -----
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module pcr_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 35,
	parameter int QUO_W = 19,
	parameter int SIDE_W = 125
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic              num_neg [pcr_pkg::AXES],
	input  logic [NUM_W-1:0]  num_mag [pcr_pkg::AXES],
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo [pcr_pkg::AXES],
	output logic              rem_nz [pcr_pkg::AXES],
	output logic              quo_neg [pcr_pkg::AXES],
	output logic [SIDE_W-1:0] side_out
);

	localparam int AX = pcr_pkg::AXES;
	localparam int CW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
	localparam int LAST = QUO_W - 1;

	logic              valid_s [QUO_W];
	logic [CW-1:0]     rem_s   [QUO_W][AX];
	logic [QUO_W-1:0]  quo_s   [QUO_W][AX];
	logic              neg_s   [QUO_W][AX];
	logic [DEN_W-1:0]  den_s   [QUO_W];
	logic [SIDE_W-1:0] side_s  [QUO_W];

	logic [CW-1:0]     rem_n   [QUO_W][AX];
	logic [QUO_W-1:0]  quo_n   [QUO_W][AX];

	// one trial subtract per stage and lane, divisor shifted to this stage's bit
	always_comb begin
		logic [CW-1:0]    src;
		logic [QUO_W-1:0] qsrc;
		logic [DEN_W-1:0] dsrc;
		logic [CW-1:0]    trial;
		for (int j = 0; j < QUO_W; j++) begin
			for (int l = 0; l < AX; l++) begin
				if (j == 0) begin
					src = CW'(num_mag[l]);
					qsrc = '0;
					dsrc = den;
				end else begin
					src = rem_s[j-1][l];
					qsrc = quo_s[j-1][l];
					dsrc = den_s[j-1];
				end
				trial = src - (CW'(dsrc) << (QUO_W - 1 - j));
				rem_n[j][l] = trial[CW-1] ? src : trial;
				quo_n[j][l] = {qsrc[QUO_W-2:0], ~trial[CW-1]};
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QUO_W; j++) valid_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < QUO_W; j++) valid_s[j] <= (j == 0) ? in_valid : valid_s[j-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QUO_W; j++) begin
				for (int l = 0; l < AX; l++) begin
					rem_s[j][l] <= rem_n[j][l];
					quo_s[j][l] <= quo_n[j][l];
					neg_s[j][l] <= (j == 0) ? num_neg[l] : neg_s[j-1][l];
				end
				den_s[j] <= (j == 0) ? den : den_s[j-1];
				side_s[j] <= (j == 0) ? side_in : side_s[j-1];
			end
		end
	end

	// last stage drives the outputs
	always_comb begin
		for (int l = 0; l < AX; l++) begin
			quo[l] = quo_s[LAST][l];
			rem_nz[l] = (rem_s[LAST][l] != '0);
			quo_neg[l] = neg_s[LAST][l];
		end
	end
	assign out_valid = valid_s[LAST];
	assign side_out = side_s[LAST];

	// remainders end below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && den_s[LAST] != '0 |->
			rem_s[LAST][0] < CW'(den_s[LAST]) && rem_s[LAST][1] < CW'(den_s[LAST]) &&
			rem_s[LAST][2] < CW'(den_s[LAST]))
		else $error("divider remainder not below divisor");

	// a stalled pipeline keeps its last item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && out_valid |=> out_valid)
		else $error("divider lost an item during stall");

	// a bubble in the next-to-last stage reaches the output
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en && !valid_s[LAST-1] |=> !out_valid)
		else $error("divider invented an item");

endmodule

// ----- hdl/particle_collision_response.sv -----
// top level: velocity reflection for sphere, box and plane colliders
// One item enters per cycle while the response side does not stall; it then passes through
// five stages of offset, scaling, dot products and products,
// then a restoring divider that resolves one quotient bit per stage for the sphere normal,
// then the saturating output register. A stall at the response side freezes the whole
// pipeline, so ready follows the output register alone. Positions and velocities are signed
// Q8.8, the plane normal is Q2.14; every result saturates to the coordinate width.
module particle_collision_response #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pcr_in_if.sink                               particle,
	pcr_out_if.source                            response,
	input  logic                                 cfg_wen,
	input  logic [pcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int AX = pcr_pkg::AXES;
	localparam int W = COORD_WIDTH;
	localparam int SLW = pcr_pkg::SLICE_W;
	localparam int DW = ((W > SLW) ? W : SLW) + 1;
	localparam int LIM = (60 - W) / 2;
	localparam int SW = (DW < LIM + 1) ? DW : LIM + 1;
	localparam int KW = $clog2(DW + 1);
	localparam int VDW = W + SW + 2;
	localparam int DDW = 2 * SW;
	localparam int SQW = DDW + 1;
	localparam int TW = VDW + SW;
	localparam int NW = TW + 3;
	localparam int QB = W + 3;
	localparam int RW = W + 9;
	localparam int VNW = W + SLW;
	localparam int SUMW = VNW + 2;
	localparam int DOTW = SUMW - pcr_pkg::DOT_SHIFT;
	localparam int PNW = DOTW + SLW;
	localparam int PRW = PNW + 1;
	localparam int CORRW = PRW - pcr_pkg::CORR_SHIFT;
	localparam int SIDE_W = 2 + AX * W + AX * RW;
	localparam logic signed [RW-1:0] R_HI = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [RW-1:0] R_LO = ~R_HI;

	// configuration registers
	logic [pcr_pkg::CFG_W-1:0] sphere_q, bmin_q, bmax_q, normal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_q <= '0;
			bmin_q <= '0;
			bmax_q <= '0;
			normal_q <= pcr_pkg::PLANE_NORMAL_RESET;
		end else if (cfg_wen) begin
			unique case (pcr_pkg::cfg_reg_t'(cfg_index))
				pcr_pkg::CFG_SPHERE_CENTER: sphere_q <= cfg_data;
				pcr_pkg::CFG_BOX_MIN:       bmin_q <= cfg_data;
				pcr_pkg::CFG_BOX_MAX:       bmax_q <= cfg_data;
				pcr_pkg::CFG_PLANE_NORMAL:  normal_q <= cfg_data;
			endcase
		end
	end

	// global advance: the output register is free or being taken
	logic out_valid_q;
	logic en;
	assign en = !out_valid_q || response.ready;
	assign particle.ready = en;

	logic signed [W-1:0] p_in [AX];
	logic signed [W-1:0] v_in [AX];
	assign p_in[0] = particle.pos_x;
	assign p_in[1] = particle.pos_y;
	assign p_in[2] = particle.pos_z;
	assign v_in[0] = particle.vel_x;
	assign v_in[1] = particle.vel_y;
	assign v_in[2] = particle.vel_z;

	// ---------------- stage 1: offsets, face distances, plane products
	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic signed [W-1:0]   v_s1 [AX];
	logic signed [DW-1:0]  d_s1 [AX];
	logic signed [DW-1:0]  dist_s1 [2*AX];
	logic signed [VNW-1:0] vn_s1 [AX];

	logic signed [DW-1:0]  d_c [AX];
	logic signed [DW-1:0]  dist_c [2*AX];
	logic signed [VNW-1:0] vn_c [AX];

	always_comb begin
		for (int i = 0; i < AX; i++) begin
			d_c[i] = DW'(p_in[i]) - DW'(pcr_pkg::cfg_slice(sphere_q, 2'(i)));
			dist_c[i] = DW'(pcr_pkg::cfg_slice(bmax_q, 2'(i))) - DW'(p_in[i]);
			dist_c[AX+i] = DW'(p_in[i]) - DW'(pcr_pkg::cfg_slice(bmin_q, 2'(i)));
			vn_c[i] = VNW'(v_in[i]) * VNW'(pcr_pkg::cfg_slice(normal_q, 2'(i)));
		end
	end

	// ---------------- stage 2: offset scaling, nearest face, plane dot
	logic                   valid_s2;
	logic [1:0]             kind_s2;
	logic signed [W-1:0]    v_s2 [AX];
	logic signed [SW-1:0]   sd_s2 [AX];
	logic                   zero_s2;
	logic [1:0]             axis_s2;
	logic signed [DOTW-1:0] dot_s2;

	logic signed [SW-1:0]   sd_c [AX];
	logic                   zero_c;
	logic [1:0]             axis_c;
	logic signed [DOTW-1:0] dot_c;

	// halve the offset until every component is below the scaling limit
	always_comb begin
		logic [DW-1:0]        mag [AX];
		logic [DW-1:0]        ormag;
		logic [KW-1:0]        bl;
		logic [KW-1:0]        ksh;
		logic [DW-1:0]        sh;
		logic signed [DW:0]   sfull;
		ormag = '0;
		for (int i = 0; i < AX; i++) begin
			mag[i] = d_s1[i][DW-1] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
			ormag = ormag | mag[i];
		end
		bl = '0;
		for (int j = 0; j < DW; j++) begin
			if (ormag[j]) bl = KW'(j + 1);
		end
		if (int'(bl) > LIM) ksh = KW'(int'(bl) - LIM);
		else ksh = '0;
		for (int i = 0; i < AX; i++) begin
			sh = mag[i] >> ksh;
			sfull = $signed({1'b0, sh});
			if (d_s1[i][DW-1]) sfull = -sfull;
			sd_c[i] = SW'(sfull);
		end
		zero_c = (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
	end

	// nearest face, earlier faces win ties
	always_comb begin
		logic signed [DW-1:0] bd;
		bd = dist_s1[0];
		axis_c = 2'd0;
		for (int j = 1; j < 2 * AX; j++) begin
			if (dist_s1[j] < bd) begin
				bd = dist_s1[j];
				axis_c = (j >= AX) ? 2'(j - AX) : 2'(j);
			end
		end
	end

	// plane dot rounded to Q8.14
	always_comb begin
		logic signed [SUMW-1:0] dsum;
		dsum = SUMW'(vn_s1[0]) + SUMW'(vn_s1[1]) + SUMW'(vn_s1[2]) + SUMW'(pcr_pkg::DOT_ROUND);
		dot_c = DOTW'(dsum >>> pcr_pkg::DOT_SHIFT);
	end

	// ---------------- stage 3: sphere dot products, box result, plane products
	logic                  valid_s3;
	logic [1:0]            kind_s3;
	logic signed [W-1:0]   v_s3 [AX];
	logic signed [SW-1:0]  sd_s3 [AX];
	logic                  zero_s3;
	logic [DDW-1:0]        dd_s3;
	logic signed [VDW-1:0] vd_s3;
	logic signed [RW-1:0]  ralt_s3 [AX];
	logic signed [PNW-1:0] pn_s3 [AX];

	logic [DDW-1:0]        dd_c;
	logic signed [VDW-1:0] vd_c;
	logic signed [RW-1:0]  ralt_c [AX];
	logic signed [PNW-1:0] pn_c [AX];

	always_comb begin
		logic signed [SQW-1:0] sq [AX];
		logic signed [SQW-1:0] sqsum;
		sqsum = '0;
		vd_c = '0;
		for (int i = 0; i < AX; i++) begin
			sq[i] = SQW'(sd_s2[i]) * SQW'(sd_s2[i]);
			sqsum = sqsum + sq[i];
			vd_c = vd_c + VDW'(v_s2[i]) * VDW'(sd_s2[i]);
			pn_c[i] = PNW'(dot_s2) * PNW'(pcr_pkg::cfg_slice(normal_q, 2'(i)));
			ralt_c[i] = RW'(v_s2[i]);
		end
		dd_c = DDW'(sqsum);
		// box flips the component of the nearest face
		if (kind_s2 == pcr_pkg::KIND_BOX) ralt_c[axis_s2] = -RW'(v_s2[axis_s2]);
	end

	// ---------------- stage 4: sphere numerator products, plane result
	logic                 valid_s4;
	logic                 usediv_s4;
	logic                 pass_s4;
	logic signed [W-1:0]  v_s4 [AX];
	logic [DDW-1:0]       dd_s4;
	logic signed [TW-1:0] t_s4 [AX];
	logic signed [RW-1:0] ralt_s4 [AX];

	logic signed [TW-1:0] t_c [AX];
	logic signed [RW-1:0] r4_c [AX];

	always_comb begin
		logic signed [PRW-1:0]   pnr;
		logic signed [CORRW-1:0] corr;
		for (int i = 0; i < AX; i++) begin
			t_c[i] = TW'(vd_s3) * TW'(sd_s3[i]);
			pnr = PRW'(pn_s3[i]) + PRW'(pcr_pkg::CORR_ROUND);
			corr = CORRW'(pnr >>> pcr_pkg::CORR_SHIFT);
			if (kind_s3 == pcr_pkg::KIND_PLANE) r4_c[i] = RW'(v_s3[i]) - RW'(corr);
			else r4_c[i] = ralt_s3[i];
		end
	end

	// ---------------- stage 5: rounded numerator magnitude and divisor
	logic                 valid_s5;
	logic                 neg_s5 [AX];
	logic [NW-1:0]        mag_s5 [AX];
	logic [DDW:0]         den_s5;
	logic [SIDE_W-1:0]    side_s5;

	logic                 neg_c [AX];
	logic [NW-1:0]        mag_c [AX];

	always_comb begin
		logic signed [NW-1:0] num;
		for (int i = 0; i < AX; i++) begin
			num = (NW'(t_s4[i]) <<< 2) + $signed(NW'(dd_s4));
			neg_c[i] = num[NW-1];
			mag_c[i] = num[NW-1] ? NW'(-num) : NW'(num);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= particle.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= particle.kind;
			for (int i = 0; i < AX; i++) begin
				v_s1[i] <= v_in[i];
				d_s1[i] <= d_c[i];
				vn_s1[i] <= vn_c[i];
			end
			for (int j = 0; j < 2 * AX; j++) dist_s1[j] <= dist_c[j];

			kind_s2 <= kind_s1;
			zero_s2 <= zero_c;
			axis_s2 <= axis_c;
			dot_s2 <= dot_c;
			for (int i = 0; i < AX; i++) begin
				v_s2[i] <= v_s1[i];
				sd_s2[i] <= sd_c[i];
			end

			kind_s3 <= kind_s2;
			zero_s3 <= zero_s2;
			dd_s3 <= dd_c;
			vd_s3 <= vd_c;
			for (int i = 0; i < AX; i++) begin
				v_s3[i] <= v_s2[i];
				sd_s3[i] <= sd_s2[i];
				ralt_s3[i] <= ralt_c[i];
				pn_s3[i] <= pn_c[i];
			end

			usediv_s4 <= (kind_s3 == pcr_pkg::KIND_SPHERE) && !zero_s3;
			pass_s4 <= (kind_s3 == pcr_pkg::KIND_SPHERE) && zero_s3;
			dd_s4 <= dd_s3;
			for (int i = 0; i < AX; i++) begin
				v_s4[i] <= v_s3[i];
				t_s4[i] <= t_c[i];
				ralt_s4[i] <= r4_c[i];
			end

			den_s5 <= {dd_s4, 1'b0};
			side_s5 <= {usediv_s4, pass_s4, v_s4[2], v_s4[1], v_s4[0],
				ralt_s4[2], ralt_s4[1], ralt_s4[0]};
			for (int i = 0; i < AX; i++) begin
				neg_s5[i] <= neg_c[i];
				mag_s5[i] <= mag_c[i];
			end
		end
	end

	// ---------------- divider
	logic              dv_valid;
	logic [QB-1:0]     dv_quo [AX];
	logic              dv_nz [AX];
	logic              dv_neg [AX];
	logic [SIDE_W-1:0] dv_side;

	pcr_div #(
		.NUM_W (NW),
		.DEN_W (DDW + 1),
		.QUO_W (QB),
		.SIDE_W(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.num_neg  (neg_s5),
		.num_mag  (mag_s5),
		.den      (den_s5),
		.side_in  (side_s5),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.rem_nz   (dv_nz),
		.quo_neg  (dv_neg),
		.side_out (dv_side)
	);

	// ---------------- final: floor quotient, subtract, saturate
	logic signed [W-1:0] vel_c [AX];
	logic                sat_c;
	logic                pass_c;

	always_comb begin
		logic                 usediv;
		logic signed [W-1:0]  vs;
		logic signed [RW-1:0] ra;
		logic signed [QB:0]   qv;
		logic signed [RW-1:0] r;
		usediv = dv_side[SIDE_W-1];
		pass_c = dv_side[SIDE_W-2];
		sat_c = 1'b0;
		for (int i = 0; i < AX; i++) begin
			vs = dv_side[AX*RW + i*W +: W];
			ra = dv_side[i*RW +: RW];
			qv = $signed({1'b0, dv_quo[i]});
			if (dv_neg[i]) qv = -qv - ((QB + 1)'(dv_nz[i]));
			r = usediv ? RW'(vs) - RW'(qv) : ra;
			if (r > R_HI) begin
				vel_c[i] = W'(R_HI);
				sat_c = 1'b1;
			end else if (r < R_LO) begin
				vel_c[i] = W'(R_LO);
				sat_c = 1'b1;
			end else begin
				vel_c[i] = W'(r);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			response.out_vel_x <= vel_c[0];
			response.out_vel_y <= vel_c[1];
			response.out_vel_z <= vel_c[2];
			response.passed_through <= pass_c;
			response.saturated <= sat_c;
		end
	end

	assign response.valid = out_valid_q;

	// an unchanged velocity is never clamped
	a_pass_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.passed_through |-> !response.saturated)
		else $error("pass-through item flagged as saturated");

	// an accepted item occupies the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		particle.valid && particle.ready |=> valid_s1)
		else $error("accepted item missing from first stage");

	// a stall holds the item in stage 3
	a_stall_s3: assert property (@(posedge clk) disable iff (!arst_n)
		!en && valid_s3 |=> valid_s3)
		else $error("item dropped from stage 3 during stall");

endmodule

// ----- verif/particle_collision_response_tb.sv -----
// testbench for the particle collision response block: directed and random items, scoreboard
module particle_collision_response_tb;

	localparam int CW = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [CW-1:0] vz;
		logic                 pass;
		logic                 sat;
	} bounce_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [pcr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcr_pkg::CFG_W-1:0] cfg_data;

	pcr_in_if #(CW) particle_ch ();
	pcr_out_if #(CW) response_ch ();

	particle_collision_response #(.COORD_WIDTH(CW)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.particle (particle_ch),
		.response (response_ch),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// shadow copy of the collider registers
	logic [pcr_pkg::CFG_W-1:0] sphere_c, box_lo, box_hi, plane_n;

	bounce_t bounce_q[$];
	int err_cnt;
	int stall_left;
	int hold_req;
	int hold_seen;
	bit no_idle;
	int quiet_cycles;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint sl(input logic [pcr_pkg::CFG_W-1:0] r, input int k);
		logic signed [pcr_pkg::SLICE_W-1:0] s;
		s = r[k*pcr_pkg::SLICE_W +: pcr_pkg::SLICE_W];
		return longint'(s);
	endfunction

	// nearest rounding with ties toward +infinity, b > 0
	function automatic longint round_quot(input longint a, input longint b);
		longint n, m, q;
		n = 2 * a + b;
		m = 2 * b;
		q = n / m;
		if (n % m != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(input longint x, inout logic sat);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			sat = 1'b1;
			return hi[CW-1:0];
		end
		if (x < lo) begin
			sat = 1'b1;
			return lo[CW-1:0];
		end
		return x[CW-1:0];
	endfunction

	// expected reflected velocity for one particle
	function automatic bounce_t reflect_velocity(input logic [1:0] k, input logic [47:0] pos,
			input logic [47:0] vel);
		longint p[3], v[3], r[3], d[3], face_d[6], n[3];
		longint dd, vd, dot, lim;
		bit big;
		int best;
		bounce_t b;
		logic sat;
		logic pass;
		sat = 1'b0;
		pass = 1'b0;
		lim = longint'(1) <<< ((60 - CW) / 2);
		for (int i = 0; i < 3; i++) begin
			p[i] = sl(pos, i);
			v[i] = sl(vel, i);
			r[i] = v[i];
		end
		case (k)
			pcr_pkg::KIND_SPHERE: begin
				for (int i = 0; i < 3; i++)
					d[i] = p[i] - sl(sphere_c, i);
				dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
				if (dd == 0) begin
					pass = 1'b1;
				end else begin
					// halve the offset until every component is below the limit
					do begin
						big = 1'b0;
						for (int i = 0; i < 3; i++)
							if (d[i] >= lim || d[i] <= -lim)
								big = 1'b1;
						if (big)
							for (int i = 0; i < 3; i++)
								d[i] = d[i] / 2;
					end while (big);
					dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
					vd = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
					for (int i = 0; i < 3; i++)
						r[i] = v[i] - round_quot(2 * vd * d[i], dd);
				end
			end
			pcr_pkg::KIND_BOX: begin
				for (int i = 0; i < 3; i++) begin
					face_d[i] = sl(box_hi, i) - p[i];
					face_d[3+i] = p[i] - sl(box_lo, i);
				end
				best = 0;
				for (int j = 1; j < 6; j++)
					if (face_d[j] < face_d[best])
						best = j;
				r[best % 3] = -v[best % 3];
			end
			pcr_pkg::KIND_PLANE: begin
				for (int i = 0; i < 3; i++)
					n[i] = sl(plane_n, i);
				dot = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
				dot = round_quot(dot, 256);
				for (int i = 0; i < 3; i++)
					r[i] = v[i] - round_quot(2 * dot * n[i], longint'(1) <<< 20);
			end
			default: begin
			end
		endcase
		b.vx = clamp_coord(r[0], sat);
		b.vy = clamp_coord(r[1], sat);
		b.vz = clamp_coord(r[2], sat);
		b.pass = pass;
		b.sat = sat;
		return b;
	endfunction

	// response side: check each item, then stall at random
	always @(posedge clk) begin
		bounce_t e;
		if (response_ch.valid && response_ch.ready) begin
			if (bounce_q.size() == 0) begin
				$error("response item with nothing expected");
				err_cnt++;
			end else begin
				e = bounce_q.pop_front();
				if (response_ch.out_vel_x !== e.vx) begin
					$error("out_vel_x exp %0d got %0d", e.vx, response_ch.out_vel_x);
					err_cnt++;
				end
				if (response_ch.out_vel_y !== e.vy) begin
					$error("out_vel_y exp %0d got %0d", e.vy, response_ch.out_vel_y);
					err_cnt++;
				end
				if (response_ch.out_vel_z !== e.vz) begin
					$error("out_vel_z exp %0d got %0d", e.vz, response_ch.out_vel_z);
					err_cnt++;
				end
				if (response_ch.passed_through !== e.pass) begin
					$error("passed_through exp %0d got %0d", e.pass,
						response_ch.passed_through);
					err_cnt++;
				end
				if (response_ch.saturated !== e.sat) begin
					$error("saturated exp %0d got %0d", e.sat, response_ch.saturated);
					err_cnt++;
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 15);
		end
		if (hold_req != hold_seen) begin
			stall_left = LONG_HOLD;
			hold_seen = hold_req;
		end
		if (stall_left > 0) begin
			stall_left--;
			response_ch.ready <= 1'b0;
		end else begin
			response_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((particle_ch.valid && particle_ch.ready) || (response_ch.valid && response_ch.ready)
				|| (bounce_q.size() == 0 && !particle_ch.valid))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// send one particle item, waiting a random gap first unless no_idle is set
	task automatic send_particle(input logic [1:0] k, input logic [47:0] pos,
			input logic [47:0] vel);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			particle_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		particle_ch.valid <= 1'b1;
		particle_ch.kind <= k;
		particle_ch.pos_x <= pos[15:0];
		particle_ch.pos_y <= pos[31:16];
		particle_ch.pos_z <= pos[47:32];
		particle_ch.vel_x <= vel[15:0];
		particle_ch.vel_y <= vel[31:16];
		particle_ch.vel_z <= vel[47:32];
		do
			@(posedge clk);
		while (!particle_ch.ready);
		bounce_q.push_back(reflect_velocity(k, pos, vel));
	endtask

	// wait for the pipeline to empty
	task automatic drain_pipe();
		particle_ch.valid <= 1'b0;
		wait (bounce_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input pcr_pkg::cfg_reg_t idx,
			input logic [pcr_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			pcr_pkg::CFG_SPHERE_CENTER: sphere_c = val;
			pcr_pkg::CFG_BOX_MIN:       box_lo = val;
			pcr_pkg::CFG_BOX_MAX:       box_hi = val;
			pcr_pkg::CFG_PLANE_NORMAL:  plane_n = val;
		endcase
	endtask

	function automatic logic [47:0] rand_vec();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	// small offset around a packed point, each slice wraps
	function automatic logic [47:0] near_point(input logic [47:0] c, input int span);
		logic [47:0] r;
		for (int i = 0; i < 3; i++)
			r[i*16 +: 16] = c[i*16 +: 16] + 16'($urandom_range(0, 2 * span) - span);
		return r;
	endfunction

	task automatic test_sphere();
		cfg_write(pcr_pkg::CFG_SPHERE_CENTER, {16'sd256, -16'sd512, 16'sd128});
		// zero offset passes through
		send_particle(pcr_pkg::KIND_SPHERE, sphere_c, {16'sd100, -16'sd200, 16'sd300});
		send_particle(pcr_pkg::KIND_SPHERE, sphere_c + 48'd1, {16'h8000, 16'h7fff, 16'h8000});
		send_particle(pcr_pkg::KIND_SPHERE, {16'h7fff, 16'h7fff, 16'h7fff},
			{16'h7fff, 16'h8000, 16'h7fff});
		send_particle(pcr_pkg::KIND_SPHERE, {16'h8000, 16'h8000, 16'h8000},
			{16'h8000, 16'h8000, 16'h8000});
		send_particle(pcr_pkg::KIND_SPHERE, 48'h0, 48'h0);
		send_particle(pcr_pkg::KIND_SPHERE, rand_vec(), rand_vec());
		drain_pipe();
	endtask

	task automatic test_box();
		cfg_write(pcr_pkg::CFG_BOX_MIN, {-16'sd256, -16'sd256, -16'sd256});
		cfg_write(pcr_pkg::CFG_BOX_MAX, {16'sd256, 16'sd256, 16'sd256});
		// every face distance equal: +x wins the tie
		send_particle(pcr_pkg::KIND_BOX, 48'h0, {16'sd3, 16'sd2, 16'sd1});
		send_particle(pcr_pkg::KIND_BOX, {16'sd0, 16'sd250, 16'sd0}, {16'sd3, 16'sd2, 16'sd1});
		send_particle(pcr_pkg::KIND_BOX, {16'sd250, 16'sd0, 16'sd0}, {16'sd3, 16'sd2, 16'sd1});
		send_particle(pcr_pkg::KIND_BOX, {16'sd0, 16'sd0, -16'sd250},
			{16'sd3, 16'sd2, 16'h8000});
		send_particle(pcr_pkg::KIND_BOX, {16'sd0, -16'sd250, 16'sd0},
			{16'sd3, 16'h8000, 16'sd1});
		send_particle(pcr_pkg::KIND_BOX, {-16'sd250, 16'sd0, 16'sd0},
			{16'h8000, 16'sd2, 16'sd1});
		send_particle(pcr_pkg::KIND_BOX, {16'sd0, 16'sd0, 16'sd0}, {16'sd0, 16'sd0, 16'h8000});
		drain_pipe();
		// inverted box
		cfg_write(pcr_pkg::CFG_BOX_MIN, {16'h7fff, 16'h7fff, 16'h7fff});
		cfg_write(pcr_pkg::CFG_BOX_MAX, {16'h8000, 16'h8000, 16'h8000});
		send_particle(pcr_pkg::KIND_BOX, rand_vec(), rand_vec());
		send_particle(pcr_pkg::KIND_BOX, {16'h8000, 16'h7fff, 16'h0}, rand_vec());
		drain_pipe();
	endtask

	task automatic test_plane();
		// reset normal is +y
		send_particle(pcr_pkg::KIND_PLANE, rand_vec(), {16'sd100, -16'sd300, 16'sd7});
		send_particle(pcr_pkg::KIND_PLANE, rand_vec(), {16'h7fff, 16'h8000, 16'h7fff});
		drain_pipe();
		// non-unit normal, used as given
		cfg_write(pcr_pkg::CFG_PLANE_NORMAL, {16'h8000, 16'h8000, 16'h8000});
		send_particle(pcr_pkg::KIND_PLANE, rand_vec(), {16'h7fff, 16'h7fff, 16'h7fff});
		send_particle(pcr_pkg::KIND_PLANE, rand_vec(), {16'sd1, -16'sd1, 16'sd0});
		drain_pipe();
		cfg_write(pcr_pkg::CFG_PLANE_NORMAL, {16'h7fff, 16'h7fff, 16'h7fff});
		send_particle(pcr_pkg::KIND_PLANE, rand_vec(), rand_vec());
	endtask

	task automatic test_unused_kind();
		send_particle(KIND_UNUSED, rand_vec(), {16'h8000, 16'h7fff, 16'h0});
		send_particle(KIND_UNUSED, rand_vec(), rand_vec());
		drain_pipe();
	endtask

	// collider settings per mode (fixed in modes 0 and 1, random otherwise), then a batch of mostly meaningful particles
	task automatic test_random_phase(input int mode, input int count);
		logic [47:0] pos;
		logic [1:0] k;
		int sel;
		case (mode)
			0: begin
				cfg_write(pcr_pkg::CFG_SPHERE_CENTER, 48'h0);
				cfg_write(pcr_pkg::CFG_BOX_MIN, {16'h8000, 16'h8000, 16'h8000});
				cfg_write(pcr_pkg::CFG_BOX_MAX, {16'h7fff, 16'h7fff, 16'h7fff});
				cfg_write(pcr_pkg::CFG_PLANE_NORMAL, {16'h0, 16'h0, 16'h4000});
			end
			1: begin
				cfg_write(pcr_pkg::CFG_SPHERE_CENTER, {16'h7fff, 16'h8000, 16'h7fff});
				cfg_write(pcr_pkg::CFG_BOX_MIN, {16'h0, 16'h0, 16'h0});
				cfg_write(pcr_pkg::CFG_BOX_MAX, {16'h0, 16'h0, 16'h0});
				cfg_write(pcr_pkg::CFG_PLANE_NORMAL, {16'h0, 16'h0, 16'hc000});
			end
			default: begin
				cfg_write(pcr_pkg::CFG_SPHERE_CENTER, rand_vec());
				cfg_write(pcr_pkg::CFG_BOX_MIN, rand_vec());
				cfg_write(pcr_pkg::CFG_BOX_MAX, rand_vec());
				cfg_write(pcr_pkg::CFG_PLANE_NORMAL, {16'($urandom_range(0, 32767) - 16384),
					16'($urandom_range(0, 32767) - 16384),
					16'($urandom_range(0, 32767) - 16384)});
			end
		endcase
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			k = (sel < 3) ? KIND_UNUSED : 2'($urandom_range(0, 2));
			sel = $urandom_range(0, 9);
			if (k == pcr_pkg::KIND_SPHERE && sel == 0)
				pos = sphere_c;
			else if (k == pcr_pkg::KIND_SPHERE && sel < 6)
				pos = near_point(sphere_c, 600);
			else if (k == pcr_pkg::KIND_BOX && sel < 7)
				pos = near_point(box_lo, 2000);
			else
				pos = rand_vec();
			send_particle(k, pos, rand_vec());
		end
		drain_pipe();
	endtask

	// receiver holds off long while items keep coming back to back
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_req++;
		for (int n = 0; n < 80; n++)
			send_particle(2'($urandom_range(0, 2)), near_point(sphere_c, 300), rand_vec());
		no_idle = 1'b0;
		drain_pipe();
	endtask

	initial begin
		no_idle = 1'b0;
		sphere_c = '0;
		box_lo = '0;
		box_hi = '0;
		plane_n = pcr_pkg::PLANE_NORMAL_RESET;
		arst_n = 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= pcr_pkg::CFG_SPHERE_CENTER;
		cfg_data <= '0;
		particle_ch.valid <= 1'b0;
		particle_ch.kind <= pcr_pkg::KIND_SPHERE;
		particle_ch.pos_x <= '0;
		particle_ch.pos_y <= '0;
		particle_ch.pos_z <= '0;
		particle_ch.vel_x <= '0;
		particle_ch.vel_y <= '0;
		particle_ch.vel_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_plane();
		test_unused_kind();
		test_sphere();
		test_box();
		for (int ph = 0; ph < 6; ph++) begin
			no_idle = (ph == 3);
			test_random_phase(ph, 210);
		end
		no_idle = 1'b0;
		test_backpressure();

		drain_pipe();
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
